// File: rtl/core/chbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the chunked body decoder.
package chbd_pkg;

   // Width of the chunk size accumulator and the remaining byte counter.
   localparam int SIZE_BITS = 32;

   // Result queue geometry. The depth must be a power of two of at least two.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Character codes used by the size line parser.
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

   typedef logic [SIZE_BITS-1:0] size_type;

   // Decoder phases.
   typedef enum logic [1:0] {
      PH_SIZE,
      PH_SKIP,
      PH_DATA,
      PH_DONE
   } phase_type;

   // Result kinds.
   typedef logic [1:0] end_kind_type;
   localparam end_kind_type END_PAYLOAD = 2'd0;
   localparam end_kind_type END_CLEAN   = 2'd1;
   localparam end_kind_type END_TRUNC   = 2'd2;

   // One result item.
   typedef struct packed {
      logic [7:0]   body_byte;
      end_kind_type end_kind;
      logic         is_last;
   } rsp_item_type;

   // Results of one processed byte: an optional payload and an optional end marker.
   typedef struct packed {
      logic         pay_vld;
      rsp_item_type pay_item;
      logic         end_vld;
      rsp_item_type end_item;
   } parse_out_type;

   // Decoded hex digit.
   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   // Maps an ASCII byte to its hex digit value, upper or lower case.
   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type r;
      r.is_hex = 1'b1;
      r.value  = '0;
      if (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9) begin
         r.value = 4'(b - CHAR_DIGIT_0);
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
         r.value = 4'(b - CHAR_LOWER_A + HEX_ALPHA_BASE);
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         r.value = 4'(b - CHAR_UPPER_A + HEX_ALPHA_BASE);
      end else begin
         r.is_hex = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/chbd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the raw body bytes and the decoded results.
interface chbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface chbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic [1:0] end_kind;
   logic       is_last;

   modport source (output valid, output body_byte, output end_kind, output is_last,
                   input ready);
   modport sink   (input valid, input body_byte, input end_kind, input is_last,
                   output ready);
endinterface

// File: rtl/core/http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the HTTP chunked body decoder.
// The decoder takes one body byte per cycle while the result queue has room and forwards
// only the chunk payload bytes, followed by one end result (clean end or truncated) on the
// byte marked final. Each byte is held in an input register, processed by the framing
// logic and written into a four-entry result queue, whose head drives the result channel.
// Sustained throughput is one byte per cycle while the result side keeps up. A final
// byte that also carries payload yields two results, drained one per cycle while the
// result side is ready. The input stalls only when fewer than two queue entries are free.
module http_chunked_body_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   chbd_req_if.sink   req_chan,
   chbd_rsp_if.source rsp_chan
);
   import chbd_pkg::*;

   logic          in_vld_ff, in_vld_in;
   logic [7:0]    in_byte_ff;
   logic          in_fin_ff;
   logic          req_fire;
   logic          room;
   logic          advance;
   parse_out_type parse_out;

   // A held byte is processed when the queue can take both of its possible results.
   assign advance        = in_vld_ff && room;
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_chan.data_byte;
         in_fin_ff  <= req_chan.final_byte;
      end
   end

   chbd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .final_byte (in_fin_ff),
      .result     (parse_out)
   );

   chbd_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (parse_out),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/core/chbd_parser.sv
`timescale 1ns / 1ps
// Chunk framing state machine: parses size lines, skips line ends, forwards data.
module chbd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   final_byte,
   output chbd_pkg::parse_out_type result
);
   import chbd_pkg::*;

   phase_type     phase_ff, phase_in, phase_proc;
   size_type      acc_ff, acc_in;
   size_type      rem_ff, rem_in;
   logic          digits_ff, digits_in;
   logic          invalid_ff, invalid_in;
   size_type      rem_dec;
   hex_digit_type hex;
   logic          is_cr;
   logic          terminal;
   logic          saturate;

   assign hex      = hex_decode(data_byte);
   assign is_cr    = (data_byte == CHAR_CR);
   assign terminal = digits_ff && !invalid_ff && (acc_ff == '0);
   assign rem_dec  = rem_ff - size_type'(1);
   // Another digit would overflow when any of the top four bits is already set.
   assign saturate = (acc_ff[SIZE_BITS-1 -: 4] != 4'd0);

   // Next phase; a final byte sends the decoder back to its reset phase.
   always_comb begin
      phase_proc = phase_ff;
      unique case (phase_ff)
         PH_SIZE: begin
            if (is_cr) begin
               phase_proc = terminal ? PH_DONE : PH_SKIP;
            end
         end
         PH_SKIP: begin
            phase_proc = (rem_ff != '0) ? PH_DATA : PH_SIZE;
         end
         PH_DATA: begin
            if (rem_dec == '0) begin
               phase_proc = PH_SIZE;
            end
         end
         PH_DONE: begin
            phase_proc = PH_DONE;
         end
      endcase
      phase_in = final_byte ? PH_SIZE : phase_proc;
   end

   // Size accumulator, remaining count and line flags.
   always_comb begin
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      digits_in  = digits_ff;
      invalid_in = invalid_ff;
      unique case (phase_ff)
         PH_SIZE: begin
            if (is_cr) begin
               if (!terminal) begin
                  rem_in = invalid_ff ? '0 : acc_ff;
               end
               acc_in     = '0;
               digits_in  = 1'b0;
               invalid_in = 1'b0;
            end else if (hex.is_hex) begin
               acc_in    = saturate ? '1 : {acc_ff[SIZE_BITS-5:0], hex.value};
               digits_in = 1'b1;
            end else begin
               invalid_in = 1'b1;
            end
         end
         PH_DATA: begin
            rem_in = rem_dec;
         end
         PH_SKIP, PH_DONE: begin
            rem_in = rem_ff;
         end
      endcase
      if (final_byte) begin
         acc_in     = '0;
         rem_in     = '0;
         digits_in  = 1'b0;
         invalid_in = 1'b0;
      end
   end

   // Result items of the current byte.
   always_comb begin
      result.pay_vld            = step && (phase_ff == PH_DATA);
      result.pay_item.body_byte = data_byte;
      result.pay_item.end_kind  = END_PAYLOAD;
      result.pay_item.is_last   = 1'b0;
      result.end_vld            = step && final_byte;
      result.end_item.body_byte = '0;
      result.end_item.end_kind  = (phase_proc == PH_DONE) ? END_CLEAN : END_TRUNC;
      result.end_item.is_last   = 1'b1;
   end

   // State registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIZE;
         acc_ff     <= '0;
         rem_ff     <= '0;
         digits_ff  <= 1'b0;
         invalid_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         rem_ff     <= rem_in;
         digits_ff  <= digits_in;
         invalid_ff <= invalid_in;
      end
   end

`ifndef ASSERT_OFF
   // The data phase is entered only with bytes left to forward.
   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> rem_ff != '0)
      else $error("data phase with zero remaining bytes");

   // Outside a chunk the remaining count is always drained.
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SIZE || phase_ff == PH_DONE) |-> rem_ff == '0)
      else $error("remaining count nonzero outside a chunk");

   // A final byte leaves the decoder in its reset state.
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      step && final_byte |=> phase_ff == PH_SIZE && acc_ff == '0 && !digits_ff
                             && !invalid_ff)
      else $error("state not cleared after final byte");
`endif

endmodule

// File: rtl/core/chbd_rsp_fifo.sv
`timescale 1ns / 1ps
// Result queue that takes up to two results per cycle and drains one per transfer.
module chbd_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  chbd_pkg::parse_out_type wr,
   output logic                    room,
   chbd_rsp_if.source              rsp_chan
);
   import chbd_pkg::*;

   rsp_item_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_CNT_W-1:0]   n_push;
   logic                   pop;
   rsp_item_type           first_item;
   rsp_item_type           head_item;

   assign n_push     = RSP_CNT_W'(wr.pay_vld) + RSP_CNT_W'(wr.end_vld);
   assign first_item = wr.pay_vld ? wr.pay_item : wr.end_item;
   assign pop        = rsp_chan.valid && rsp_chan.ready;
   // Room for the worst case of two results from one byte.
   assign room       = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   // Pointer and occupancy updates.
   always_comb begin
      tail_in  = tail_ff + RSP_PTR_W'(n_push);
      head_in  = pop ? head_ff + RSP_PTR_W'(1) : head_ff;
      count_in = count_ff + n_push - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage writes: the payload goes first, the end marker behind it.
   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         mem_ff[tail_ff] <= first_item;
      end
      if (wr.pay_vld && wr.end_vld) begin
         mem_ff[tail_ff + RSP_PTR_W'(1)] <= wr.end_item;
      end
   end

   // Head of queue drives the result channel.
   assign head_item          = mem_ff[head_ff];
   assign rsp_chan.valid     = (count_ff != '0);
   assign rsp_chan.body_byte = head_item.body_byte;
   assign rsp_chan.end_kind  = head_item.end_kind;
   assign rsp_chan.is_last   = head_item.is_last;

`ifndef ASSERT_OFF
   // Occupancy never exceeds the storage.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // Writes arrive only while room was reported.
   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      n_push != '0 |-> room)
      else $error("result written without room");

   // A waiting result holds steady until it is transferred.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(head_item))
      else $error("waiting result changed before transfer");
`endif

endmodule
